// ===== design/tdne_pkg.sv =====
// Shared types, codes and defaults for the token dictionary name expander.
package tdne_pkg;

    localparam int TdneTextBytes   = 4096;
    localparam int TdneMaxTokenLen = 32;
    localparam int TdneIndexDepth  = 256;
    localparam logic [7:0] TdneMaxNameLenReset = 8'd128;

    localparam int ReqW  = 2;
    localparam int AddrW = 12;
    localparam int ValW  = 12;
    localparam int ByteW = 8;
    localparam int LenW  = 15;

    localparam logic [ReqW-1:0] REQ_INDEX  = 2'd0;
    localparam logic [ReqW-1:0] REQ_TEXT   = 2'd1;
    localparam logic [ReqW-1:0] REQ_STREAM = 2'd2;

    localparam logic [ByteW-1:0] HDR_EXT_MASK = 8'h80;
    localparam logic [ByteW-1:0] HDR_LOW_MASK = 8'h7F;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_HIGH,
        PH_TOKENS
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INDEX,
        S_REDUCE,
        S_WALK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ByteW-1:0] out_char;
        logic             char_valid;
        logic             end_of_name;
        logic [ByteW-1:0] name_chars;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result data;
    } t_push;

endpackage

// ===== design/tdne_ifs.sv =====
// Valid/ready channel interfaces for request and result items.
interface tdne_req_if import tdne_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ReqW-1:0]  req_type;
    logic [AddrW-1:0] load_addr;
    logic [ValW-1:0]  load_value;
    logic [ByteW-1:0] stream_byte;

    modport source (output valid, req_type, load_addr, load_value, stream_byte,
                    input ready);
    modport sink   (input valid, req_type, load_addr, load_value, stream_byte,
                    output ready);
endinterface

interface tdne_res_if import tdne_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_char;
    logic             char_valid;
    logic             end_of_name;
    logic [ByteW-1:0] name_chars;

    modport source (output valid, out_char, char_valid, end_of_name, name_chars,
                    input ready);
    modport sink   (input valid, out_char, char_valid, end_of_name, name_chars,
                    output ready);
endinterface

// ===== design/tdne_out_stage.sv =====
// Single-entry result register between the expander core and the result channel.
module tdne_out_stage import tdne_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_push          i_push,
    output logic           o_space,
    tdne_res_if.source     o_res
);

    logic    r_valid;
    t_result r_data;

    assign o_space = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_push.push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_push.push) begin
            r_data <= i_push.data;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.out_char    = r_data.out_char;
    assign o_res.char_valid  = r_data.char_valid;
    assign o_res.end_of_name = r_data.end_of_name;
    assign o_res.name_chars  = r_data.name_chars;

endmodule

// ===== design/token_dictionary_name_expander.sv =====
// Top level: token-compressed symbol name expander with index and text memories.
//
// Load items (type 0, 1) write one entry of the 256-entry token index or one
// byte of the token text store; type 3 is dropped.
// Name stream items (type 2) carry a length header (one or two bytes)
// followed by token codes. A token code walks up to MAX_TOKEN_LEN text bytes,
// counting the closing NUL. Its steps are: accept, the index memory read,
// the text walk at one byte per cycle (unless stalled by a full result
// register) through the single read port of the text memory, and a flush
// of the held-back character. When TEXT_BYTES is below 4096, the text offset
// is brought into range by repeated subtraction before the walk. Each emitted
// character is held back until a later one is emitted or its token ends, so
// that the last character of a name can carry the end mark; a name whose last
// token emits nothing ends with an empty result (char_valid 0). A full result
// register stalls the walk. No clearing pass: unwritten memory entries are
// undefined. max_name_len is written through i_cfg_we / i_cfg_data; the user
// writes it while the block is idle, which the block itself does not enforce.
module token_dictionary_name_expander import tdne_pkg::*; #(
    parameter int TEXT_BYTES    = TdneTextBytes,
    parameter int MAX_TOKEN_LEN = TdneMaxTokenLen
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ByteW-1:0] i_cfg_data,
    tdne_req_if.sink         i_req,
    tdne_res_if.source       o_res
);

    localparam int TaW  = $clog2(TEXT_BYTES);
    localparam int MW   = ((TaW > AddrW) ? TaW : AddrW) + 1;
    localparam int CntW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IxW  = $clog2(TdneIndexDepth);
    localparam logic [MW-1:0]   TextBytesM = MW'(TEXT_BYTES);
    localparam logic [TaW-1:0]  TextLast   = TaW'(TEXT_BYTES - 1);
    localparam logic [CntW-1:0] CntLast    = CntW'(MAX_TOKEN_LEN - 1);

    // Memories
    logic [ValW-1:0]  index_mem [TdneIndexDepth];
    logic [ByteW-1:0] text_mem  [TEXT_BYTES];
    logic [ValW-1:0]  r_index_q;
    logic [ByteW-1:0] r_text_q;

    // Control and datapath state
    t_state           r_state, n_state;
    t_phase           r_phase;
    logic [LenW-1:0]  r_tokens;
    logic [6:0]       r_low_hdr;
    logic             r_first;
    logic [ByteW-1:0] r_chars;
    logic [ByteW-1:0] r_max_len;
    logic             r_last;
    logic             r_pend_v;
    t_result          r_pend;
    logic [MW-1:0]    r_red;
    logic [TaW-1:0]   r_pos;
    logic [CntW-1:0]  r_cnt;

    // Combinational
    logic             accept;
    logic [MW-1:0]    addr_ext;
    logic [ByteW-1:0] limit;
    logic [TaW-1:0]   pos_inc;
    logic             nul;
    logic             will_emit;
    logic             need_push;
    logic             stall;
    logic             adv;
    logic             walk_end;
    logic             reduce_done;
    logic [LenW-1:0]  hdr_len;
    logic [LenW-1:0]  tok_dec;
    logic [TaW-1:0]   rd_addr;
    logic             space;
    t_push            push;

    assign accept   = i_req.valid && i_req.ready;
    assign addr_ext = MW'(i_req.load_addr);
    assign limit    = (r_max_len != '0) ? r_max_len - 8'd1 : '0;
    assign pos_inc  = (r_pos == TextLast) ? '0 : r_pos + TaW'(1);
    assign hdr_len  = {i_req.stream_byte, r_low_hdr};
    assign tok_dec  = r_tokens - LenW'(1);

    // Walk: one byte per cycle unless stalled; held-back char pushed on emit
    always_comb begin
        nul         = (r_text_q == '0);
        will_emit   = !nul && r_first && (r_chars < limit);
        need_push   = will_emit && r_pend_v;
        stall       = need_push && !space;
        adv         = (r_state == S_WALK) && !nul && !stall;
        walk_end    = (r_cnt == CntLast);
        reduce_done = (r_red < TextBytesM);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req.req_type == REQ_STREAM) begin
                    unique case (r_phase)
                        PH_HEADER: begin
                            if ((i_req.stream_byte & HDR_EXT_MASK) == '0 &&
                                i_req.stream_byte == '0) begin
                                n_state = S_FINISH;
                            end
                        end
                        PH_HIGH: begin
                            if (hdr_len == '0) begin
                                n_state = S_FINISH;
                            end
                        end
                        PH_TOKENS: n_state = S_INDEX;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_INDEX:  n_state = S_REDUCE;
            S_REDUCE: begin
                if (reduce_done) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (nul || (adv && walk_end)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!(r_pend_v || r_last) || space) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: request ready, result push, text read address
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        push.push   = 1'b0;
        push.data   = r_pend;
        rd_addr     = r_pos;
        unique case (r_state)
            S_REDUCE: rd_addr = r_red[TaW-1:0];
            S_WALK: begin
                push.push = need_push && space;
                push.data.end_of_name = 1'b0;
                if (adv && !walk_end) begin
                    rd_addr = pos_inc;
                end
            end
            S_FINISH: begin
                push.push = (r_pend_v || r_last) && space;
                if (r_pend_v) begin
                    push.data.end_of_name = r_last;
                end else begin
                    push.data.out_char    = '0;
                    push.data.char_valid  = 1'b0;
                    push.data.end_of_name = 1'b1;
                    push.data.name_chars  = r_chars;
                end
            end
            default: ;
        endcase
    end

    // Memory writes only while idle; reads every cycle, registered
    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type == REQ_INDEX &&
            i_req.load_addr[AddrW-1:IxW] == '0) begin
            index_mem[i_req.load_addr[IxW-1:0]] <= i_req.load_value;
        end
        r_index_q <= index_mem[i_req.stream_byte];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type == REQ_TEXT && addr_ext < TextBytesM) begin
            text_mem[addr_ext[TaW-1:0]] <= i_req.load_value[ByteW-1:0];
        end
        r_text_q <= text_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_HEADER;
            r_tokens  <= '0;
            r_first   <= 1'b0;
            r_chars   <= '0;
            r_max_len <= TdneMaxNameLenReset;
            r_pend_v  <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (accept && i_req.req_type == REQ_STREAM) begin
                unique case (r_phase)
                    PH_HEADER: begin
                        // start of a name
                        r_first  <= 1'b0;
                        r_chars  <= '0;
                        r_pend_v <= 1'b0;
                        if ((i_req.stream_byte & HDR_EXT_MASK) != '0) begin
                            r_phase <= PH_HIGH;
                        end else begin
                            r_tokens <= LenW'(i_req.stream_byte);
                            r_last   <= (i_req.stream_byte == '0);
                            r_phase  <= (i_req.stream_byte == '0) ? PH_HEADER
                                                                  : PH_TOKENS;
                        end
                    end
                    PH_HIGH: begin
                        r_tokens <= hdr_len;
                        r_last   <= (hdr_len == '0);
                        r_phase  <= (hdr_len == '0) ? PH_HEADER : PH_TOKENS;
                    end
                    PH_TOKENS: begin
                        r_tokens <= tok_dec;
                        r_last   <= (tok_dec == '0);
                        if (tok_dec == '0) begin
                            r_phase <= PH_HEADER;
                        end
                    end
                    default: r_phase <= PH_HEADER;
                endcase
            end
            if (adv) begin
                r_first <= 1'b1;
                if (will_emit) begin
                    r_pend_v <= 1'b1;
                    r_chars  <= r_chars + 8'd1;
                end
            end
            if (r_state == S_FINISH && space) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept && r_phase == PH_HEADER) begin
            r_low_hdr <= i_req.stream_byte[6:0] & HDR_LOW_MASK[6:0];
        end
        if (r_state == S_INDEX) begin
            r_red <= MW'(r_index_q);
        end else if (r_state == S_REDUCE && !reduce_done) begin
            r_red <= r_red - TextBytesM;
        end
        if (r_state == S_REDUCE) begin
            r_pos <= r_red[TaW-1:0];
            r_cnt <= '0;
        end else if (adv) begin
            r_pos <= pos_inc;
            r_cnt <= r_cnt + CntW'(1);
        end
        if (adv && will_emit) begin
            r_pend.out_char    <= r_text_q;
            r_pend.char_valid  <= 1'b1;
            r_pend.end_of_name <= 1'b0;
            r_pend.name_chars  <= r_chars + 8'd1;
        end
    end

    tdne_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_res   (o_res)
    );

endmodule

// ===== design/tdne_checker.sv =====
// Port-level assertions for the name expander, bound to the top level.
module tdne_checker import tdne_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [ByteW-1:0] i_out_char,
    input logic             i_char_valid,
    input logic             i_end_of_name,
    input logic [ByteW-1:0] i_name_chars
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_char_valid |-> i_end_of_name && i_out_char == '0)
        else $error("empty result without end mark or with a character");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_char_valid |-> i_name_chars != '0 && i_out_char != '0)
        else $error("character result with zero count or NUL character");

endmodule

bind token_dictionary_name_expander tdne_checker u_tdne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_out_char    (o_res.out_char),
    .i_char_valid  (o_res.char_valid),
    .i_end_of_name (o_res.end_of_name),
    .i_name_chars  (o_res.name_chars)
);
